// ===== hdl/ptd_pkg.sv =====
// Shared types and constants for the point-to-triangle distance block.
// Request and result payload structs, field widths and configuration register indexes.
package ptd_pkg;

  localparam int COORD_W   = 16;
  localparam int DIST_W    = 25;
  localparam int NUM_EDGES = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_V0X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_V0Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_V1X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_V1Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_V2X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_V2Y = 3'd5;

  typedef struct packed {
    logic signed [COORD_W-1:0] query_x;
    logic signed [COORD_W-1:0] query_y;
  } in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              degenerate;
  } out_t;

endpackage

// ===== hdl/ptd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, one lane per edge.
// Carries a sideband vector and valid bit alongside; depends on ptd_pkg.
module ptd_div import ptd_pkg::*; #(
  parameter int NUM_W  = 84,
  parameter int DEN_W  = 34,
  parameter int QUO_W  = 50,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [NUM_W-1:0]  num_i  [NUM_EDGES],
  input  logic [DEN_W-1:0]  den_i  [NUM_EDGES],
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [QUO_W-1:0]  quo_o  [NUM_EDGES],
  output logic [SIDE_W-1:0] side_o
);

  logic [DEN_W-1:0]  rem_r  [QUO_W][NUM_EDGES];
  logic [QUO_W-1:0]  lo_r   [QUO_W][NUM_EDGES];
  logic [DEN_W-1:0]  den_r  [QUO_W][NUM_EDGES];
  logic [SIDE_W-1:0] side_r [QUO_W];
  logic [QUO_W-1:0]  vld_r;

  for (genvar g = 0; g < QUO_W; g++) begin : g_stage
    logic [DEN_W-1:0]  rem_in  [NUM_EDGES];
    logic [QUO_W-1:0]  lo_in   [NUM_EDGES];
    logic [DEN_W-1:0]  den_in  [NUM_EDGES];
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic [DEN_W:0]    cand    [NUM_EDGES];
    logic [DEN_W:0]    diff    [NUM_EDGES];
    logic              take    [NUM_EDGES];

    if (g == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < NUM_EDGES; l++) begin
          rem_in[l] = num_i[l][NUM_W-1 -: DEN_W];
          lo_in[l]  = num_i[l][QUO_W-1:0];
          den_in[l] = den_i[l];
        end
        side_in = side_i;
        vld_in  = vld_i;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < NUM_EDGES; l++) begin
          rem_in[l] = rem_r[g-1][l];
          lo_in[l]  = lo_r[g-1][l];
          den_in[l] = den_r[g-1][l];
        end
        side_in = side_r[g-1];
        vld_in  = vld_r[g-1];
      end
    end

    always_comb begin
      for (int l = 0; l < NUM_EDGES; l++) begin
        cand[l] = {rem_in[l], lo_in[l][QUO_W-1]};
        take[l] = (cand[l] >= {1'b0, den_in[l]});
        diff[l] = cand[l] - {1'b0, den_in[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < NUM_EDGES; l++) begin
          rem_r[g][l] <= take[l] ? diff[l][DEN_W-1:0] : cand[l][DEN_W-1:0];
          lo_r[g][l]  <= {lo_in[l][QUO_W-2:0], take[l]};
          den_r[g][l] <= den_in[l];
        end
        side_r[g] <= side_in;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_EDGES; l++) begin
      quo_o[l] = lo_r[QUO_W-1][l];
    end
  end

  assign side_o = side_r[QUO_W-1];
  assign vld_o  = vld_r[QUO_W-1];

endmodule

// ===== hdl/point_triangle_distance_2d.sv =====
// Pipeline: five setup stages, one stage per quotient bit of the edge divider, a min stage,
// and one stage per root bit of the square root.
// Throughput: one request per cycle; a stalled result holds every stage in place.
// Reset (rst_n, synchronous): clears all valid bits and the vertex registers to 0.
// Depends on ptd_pkg and ptd_div.
module point_triangle_distance_2d import ptd_pkg::*; #(
  parameter int DIST_FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [COORD_W-1:0]   cfg_wdata
);

  localparam int F      = DIST_FRAC_BITS;
  localparam int DW     = COORD_W + 1;
  localparam int PW     = 2 * DW;
  localparam int SW     = PW + 1;
  localparam int MW     = PW;
  localparam int QUO_W  = MW + 2 * F;
  localparam int NUM_W  = 2 * MW + 2 * F;
  localparam int ROOT_W = QUO_W / 2;
  localparam int REM_W  = ROOT_W + 1;
  localparam int SIDE_W = 2 + NUM_EDGES + NUM_EDGES * QUO_W;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // vertex registers
  logic signed [COORD_W-1:0] vx_r [NUM_EDGES];
  logic signed [COORD_W-1:0] vy_r [NUM_EDGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_EDGES; k++) begin
        vx_r[k] <= '0;
        vy_r[k] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_V0X: vx_r[0] <= cfg_wdata;
        REG_V0Y: vy_r[0] <= cfg_wdata;
        REG_V1X: vx_r[1] <= cfg_wdata;
        REG_V1Y: vy_r[1] <= cfg_wdata;
        REG_V2X: vx_r[2] <= cfg_wdata;
        REG_V2Y: vy_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage 1: offsets and edge vectors
  logic              s1_vld_r;
  logic signed [DW-1:0] s1_dx_r [NUM_EDGES];
  logic signed [DW-1:0] s1_dy_r [NUM_EDGES];
  logic signed [DW-1:0] s1_ex_r [NUM_EDGES];
  logic signed [DW-1:0] s1_ey_r [NUM_EDGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_EDGES; k++) begin
        s1_dx_r[k] <= DW'(in_data.query_x) - DW'(vx_r[k]);
        s1_dy_r[k] <= DW'(in_data.query_y) - DW'(vy_r[k]);
        s1_ex_r[k] <= DW'(vx_r[(k == NUM_EDGES-1) ? 0 : k+1]) - DW'(vx_r[k]);
        s1_ey_r[k] <= DW'(vy_r[(k == NUM_EDGES-1) ? 0 : k+1]) - DW'(vy_r[k]);
      end
    end
  end

  // stage 2: products
  logic                 s2_vld_r;
  logic signed [PW-1:0] s2_tp1_r [NUM_EDGES];
  logic signed [PW-1:0] s2_tp2_r [NUM_EDGES];
  logic signed [PW-1:0] s2_ep1_r [NUM_EDGES];
  logic signed [PW-1:0] s2_ep2_r [NUM_EDGES];
  logic signed [PW-1:0] s2_cp1_r [NUM_EDGES];
  logic signed [PW-1:0] s2_cp2_r [NUM_EDGES];
  logic signed [PW-1:0] s2_dp1_r [NUM_EDGES];
  logic signed [PW-1:0] s2_dp2_r [NUM_EDGES];
  logic signed [PW-1:0] s2_ar1_r;
  logic signed [PW-1:0] s2_ar2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_EDGES; k++) begin
        s2_tp1_r[k] <= PW'(s1_dx_r[k]) * PW'(s1_ex_r[k]);
        s2_tp2_r[k] <= PW'(s1_dy_r[k]) * PW'(s1_ey_r[k]);
        s2_ep1_r[k] <= PW'(s1_ex_r[k]) * PW'(s1_ex_r[k]);
        s2_ep2_r[k] <= PW'(s1_ey_r[k]) * PW'(s1_ey_r[k]);
        s2_cp1_r[k] <= PW'(s1_dx_r[k]) * PW'(s1_ey_r[k]);
        s2_cp2_r[k] <= PW'(s1_dy_r[k]) * PW'(s1_ex_r[k]);
        s2_dp1_r[k] <= PW'(s1_dx_r[k]) * PW'(s1_dx_r[k]);
        s2_dp2_r[k] <= PW'(s1_dy_r[k]) * PW'(s1_dy_r[k]);
      end
      s2_ar1_r <= PW'(s1_ey_r[0]) * PW'(s1_ex_r[2]);
      s2_ar2_r <= PW'(s1_ex_r[0]) * PW'(s1_ey_r[2]);
    end
  end

  // stage 3: dot, length, cross, vertex distance and area sums
  logic                 s3_vld_r;
  logic signed [SW-1:0] s3_t_r  [NUM_EDGES];
  logic [MW-1:0]        s3_ee_r [NUM_EDGES];
  logic signed [SW-1:0] s3_cr_r [NUM_EDGES];
  logic [MW-1:0]        s3_dd_r [NUM_EDGES];
  logic signed [SW-1:0] s3_area_r;
  logic signed [SW-1:0] ee_sum [NUM_EDGES];
  logic signed [SW-1:0] dd_sum [NUM_EDGES];

  always_comb begin
    for (int k = 0; k < NUM_EDGES; k++) begin
      ee_sum[k] = SW'(s2_ep1_r[k]) + SW'(s2_ep2_r[k]);
      dd_sum[k] = SW'(s2_dp1_r[k]) + SW'(s2_dp2_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_EDGES; k++) begin
        s3_t_r[k]  <= SW'(s2_tp1_r[k]) + SW'(s2_tp2_r[k]);
        s3_ee_r[k] <= ee_sum[k][MW-1:0];
        s3_cr_r[k] <= SW'(s2_cp1_r[k]) - SW'(s2_cp2_r[k]);
        s3_dd_r[k] <= dd_sum[k][MW-1:0];
      end
      s3_area_r <= SW'(s2_ar1_r) - SW'(s2_ar2_r);
    end
  end

  // stage 4: region decisions
  logic                 s4_vld_r;
  logic                 s4_deg_r;
  logic                 s4_zero_r;
  logic [MW-1:0]        s4_mag_r  [NUM_EDGES];
  logic [MW-1:0]        s4_ee_r   [NUM_EDGES];
  logic [QUO_W-1:0]     s4_vsel_r [NUM_EDGES];
  logic [NUM_EDGES-1:0] s4_div_r;
  logic                 degen;
  logic                 all_le;
  logic                 all_ge;
  logic                 in_tri;
  logic                 near_end  [NUM_EDGES];
  logic                 far_end   [NUM_EDGES];
  logic signed [SW-1:0] mag_s     [NUM_EDGES];

  always_comb begin
    degen  = (s3_area_r == '0);
    all_le = 1'b1;
    all_ge = 1'b1;
    for (int k = 0; k < NUM_EDGES; k++) begin
      all_le     = all_le && (s3_cr_r[k] <= 0);
      all_ge     = all_ge && (s3_cr_r[k] >= 0);
      near_end[k] = (s3_ee_r[k] == '0) || (s3_t_r[k] <= 0);
      far_end[k]  = (s3_t_r[k] >= $signed({1'b0, s3_ee_r[k]}));
      mag_s[k]    = (s3_cr_r[k] < 0) ? -s3_cr_r[k] : s3_cr_r[k];
    end
    in_tri = (s3_area_r > 0) ? all_le : all_ge;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_deg_r  <= degen;
      s4_zero_r <= degen || in_tri;
      for (int k = 0; k < NUM_EDGES; k++) begin
        s4_mag_r[k] <= mag_s[k][MW-1:0];
        s4_ee_r[k]  <= s3_ee_r[k];
        s4_div_r[k] <= !near_end[k] && !far_end[k];
        if (near_end[k]) begin
          s4_vsel_r[k] <= QUO_W'(s3_dd_r[k]) << (2 * F);
        end else begin
          s4_vsel_r[k] <= QUO_W'(s3_dd_r[(k == NUM_EDGES-1) ? 0 : k+1]) << (2 * F);
        end
      end
    end
  end

  // stage 5: scaled squared cross product
  logic                 s5_vld_r;
  logic [NUM_W-1:0]     s5_num_r  [NUM_EDGES];
  logic [MW-1:0]        s5_ee_r   [NUM_EDGES];
  logic [SIDE_W-1:0]    s5_side_r;
  logic [2*MW-1:0]      sq        [NUM_EDGES];

  always_comb begin
    for (int k = 0; k < NUM_EDGES; k++) begin
      sq[k] = (2*MW)'(s4_mag_r[k]) * (2*MW)'(s4_mag_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_EDGES; k++) begin
        s5_num_r[k] <= NUM_W'(sq[k]) << (2 * F);
        s5_ee_r[k]  <= s4_ee_r[k];
      end
      s5_side_r <= {s4_deg_r, s4_zero_r, s4_div_r, s4_vsel_r[2], s4_vsel_r[1], s4_vsel_r[0]};
    end
  end

  // edge divider
  logic              dv_vld;
  logic [QUO_W-1:0]  dv_quo [NUM_EDGES];
  logic [SIDE_W-1:0] dv_side;

  ptd_div #(
    .NUM_W  (NUM_W),
    .DEN_W  (MW),
    .QUO_W  (QUO_W),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (s5_vld_r),
    .num_i  (s5_num_r),
    .den_i  (s5_ee_r),
    .side_i (s5_side_r),
    .vld_o  (dv_vld),
    .quo_o  (dv_quo),
    .side_o (dv_side)
  );

  // min stage
  logic             m_vld_r;
  logic             m_deg_r;
  logic [QUO_W-1:0] m_rad_r;
  logic [QUO_W-1:0] val [NUM_EDGES];
  logic [QUO_W-1:0] best;

  always_comb begin
    for (int k = 0; k < NUM_EDGES; k++) begin
      val[k] = dv_side[NUM_EDGES*QUO_W + k] ? dv_quo[k] : dv_side[k*QUO_W +: QUO_W];
    end
    best = val[0];
    for (int k = 1; k < NUM_EDGES; k++) begin
      if (val[k] < best) begin
        best = val[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_deg_r <= dv_side[SIDE_W-1];
      m_rad_r <= dv_side[SIDE_W-2] ? '0 : best;
    end
  end

  // square root, one root bit per stage
  logic [REM_W-1:0]  sq_rem_r  [ROOT_W];
  logic [ROOT_W-1:0] sq_root_r [ROOT_W];
  logic [QUO_W-1:0]  sq_rad_r  [ROOT_W];
  logic [ROOT_W-1:0] sq_deg_r;
  logic [ROOT_W-1:0] sq_vld_r;

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [QUO_W-1:0]  rad_in;
    logic              deg_in;
    logic              vld_in;
    logic [REM_W+1:0]  cand;
    logic [REM_W+1:0]  trial;
    logic              take;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = m_rad_r;
      assign deg_in  = m_deg_r;
      assign vld_in  = m_vld_r;
    end else begin : g_next
      assign rem_in  = sq_rem_r[g-1];
      assign root_in = sq_root_r[g-1];
      assign rad_in  = sq_rad_r[g-1];
      assign deg_in  = sq_deg_r[g-1];
      assign vld_in  = sq_vld_r[g-1];
    end

    assign cand  = {rem_in, rad_in[QUO_W-1 -: 2]};
    assign trial = (REM_W+2)'({root_in, 2'b01});
    assign take  = (cand >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[g] <= 1'b0;
      end else if (en) begin
        sq_vld_r[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[g]  <= take ? REM_W'(cand - trial) : REM_W'(cand);
        sq_root_r[g] <= {root_in[ROOT_W-2:0], take};
        sq_rad_r[g]  <= rad_in << 2;
        sq_deg_r[g]  <= deg_in;
      end
    end
  end

  assign out_valid           = sq_vld_r[ROOT_W-1];
  assign out_data.distance   = DIST_W'(sq_root_r[ROOT_W-1]);
  assign out_data.degenerate = sq_deg_r[ROOT_W-1];

endmodule
